@@ hw/rtl/rbw_pkg.sv @@
// Shared types, register codes and fixed-point helpers for the rigid body wrench model.
// No dependencies; every other file in hw/rtl imports this package.
package rbw_pkg;

  // Fixed-point format and pipeline depth
  localparam int Q         = 16;
  localparam int NSTG      = 6;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COM_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COM_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COM_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IXX_IXY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IXZ_IYY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IYZ_IZZ   = 3'd6;

  // Component rotation for cross products: r[k] = u[NX1]v[NX2] - u[NX2]v[NX1]
  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  typedef logic signed [31:0] s32_t;
  typedef logic signed [47:0] prod_t;   // Q16.16 product after the shift
  typedef logic signed [50:0] sum_t;    // widest exact sum in the datapath

  localparam sum_t SUM_MAX = 51'sd2147483647;
  localparam sum_t SUM_MIN = -51'sd2147483648;

  typedef struct packed {
    logic signed [31:0] lin_acc_x;
    logic signed [31:0] lin_acc_y;
    logic signed [31:0] lin_acc_z;
    logic signed [31:0] ang_acc_x;
    logic signed [31:0] ang_acc_y;
    logic signed [31:0] ang_acc_z;
    logic signed [31:0] ang_vel_x;
    logic signed [31:0] ang_vel_y;
    logic signed [31:0] ang_vel_z;
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic signed [31:0] grav_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } out_word_t;

  typedef struct packed {
    logic        [30:0] mass;
    logic signed [31:0] com_x;
    logic signed [31:0] com_y;
    logic signed [31:0] com_z;
    logic signed [31:0] i_xx;
    logic signed [31:0] i_xy;
    logic signed [31:0] i_xz;
    logic signed [31:0] i_yy;
    logic signed [31:0] i_yz;
    logic signed [31:0] i_zz;
  } cfg_t;

  // Q16.16 multiply, arithmetic shift (floor)
  function automatic prod_t qmul(s32_t x, s32_t y);
    logic signed [63:0] p;
    p = x * y;
    return prod_t'(p >>> Q);
  endfunction

  // Saturate a wide sum to the signed 32-bit range
  function automatic s32_t sat32(sum_t v);
    s32_t r;
    if (v > SUM_MAX) r = 32'sh7fffffff;
    else if (v < SUM_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/rbw_cfg.sv @@
// Configuration register file: mass, center of mass and packed inertia terms.
// Depends on rbw_pkg.
module rbw_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rbw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                        cfg_data,
  output rbw_pkg::cfg_t                      cfg
);
  import rbw_pkg::*;

  // Writes are always accepted, never stalled
  assign cfg_ready = 1'b1;

  // Register writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASS:    cfg.mass  <= cfg_data[30:0];
        REG_COM_X:   cfg.com_x <= cfg_data[31:0];
        REG_COM_Y:   cfg.com_y <= cfg_data[31:0];
        REG_COM_Z:   cfg.com_z <= cfg_data[31:0];
        REG_IXX_IXY: begin
          cfg.i_xx <= cfg_data[63:32];
          cfg.i_xy <= cfg_data[31:0];
        end
        REG_IXZ_IYY: begin
          cfg.i_xz <= cfg_data[63:32];
          cfg.i_yy <= cfg_data[31:0];
        end
        REG_IYZ_IZZ: begin
          cfg.i_yz <= cfg_data[63:32];
          cfg.i_zz <= cfg_data[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/rbw_ctl.sv @@
// Pipeline flow control: per-stage valid bits and bubble-collapsing load enables.
// Depends on rbw_pkg.
module rbw_ctl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [rbw_pkg::NSTG-1:0]  load,
  output logic [rbw_pkg::NSTG-1:0]  stage_v
);
  import rbw_pkg::*;

  // A stage loads when empty or when its word moves on
  always_comb begin
    load[NSTG-1] = !stage_v[NSTG-1] || result_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !stage_v[k] || load[k+1];
    end
  end

  assign item_ready   = load[0];
  assign result_valid = stage_v[NSTG-1];

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      if (load[0]) stage_v[0] <= item_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) stage_v[k] <= stage_v[k-1];
      end
    end
  end

endmodule

@@ hw/rtl/rbw_dpath.sv @@
// Six-stage wrench datapath: products, cross sums, second products, force and torque.
// Depends on rbw_pkg; stage enables come from rbw_ctl, constants from rbw_cfg.
module rbw_dpath (
  input  logic                      clk,
  input  rbw_pkg::cfg_t             cfg,
  input  logic [rbw_pkg::NSTG-1:0]  load,
  input  rbw_pkg::in_word_t         item,
  output rbw_pkg::out_word_t        result
);
  import rbw_pkg::*;

  s32_t a_in [3];
  s32_t al_in [3];
  s32_t om_in [3];
  s32_t g_in [3];
  s32_t c [3];
  s32_t im [3][3];
  s32_t m;

  // Unpack the input word and configuration
  always_comb begin
    a_in[0] = item.lin_acc_x;  a_in[1] = item.lin_acc_y;  a_in[2] = item.lin_acc_z;
    al_in[0] = item.ang_acc_x; al_in[1] = item.ang_acc_y; al_in[2] = item.ang_acc_z;
    om_in[0] = item.ang_vel_x; om_in[1] = item.ang_vel_y; om_in[2] = item.ang_vel_z;
    g_in[0] = item.grav_x;     g_in[1] = item.grav_y;     g_in[2] = item.grav_z;
    c[0] = cfg.com_x; c[1] = cfg.com_y; c[2] = cfg.com_z;
    im[0][0] = cfg.i_xx; im[0][1] = cfg.i_xy; im[0][2] = cfg.i_xz;
    im[1][0] = cfg.i_xy; im[1][1] = cfg.i_yy; im[1][2] = cfg.i_yz;
    im[2][0] = cfg.i_xz; im[2][1] = cfg.i_yz; im[2][2] = cfg.i_zz;
    m = {1'b0, cfg.mass};
  end

  // Stage 1: first products and a - g
  s32_t  a_1 [3], g_1 [3], om_1 [3], d_1 [3];
  prod_t pomc_u [3], pomc_n [3], palc_u [3], palc_n [3];
  prod_t piw [3][3], pia [3][3];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      for (int k = 0; k < 3; k++) begin
        a_1[k]    <= a_in[k];
        g_1[k]    <= g_in[k];
        om_1[k]   <= om_in[k];
        d_1[k]    <= sat32(sum_t'(a_in[k]) - sum_t'(g_in[k]));
        pomc_u[k] <= qmul(om_in[NX1[k]], c[NX2[k]]);
        pomc_n[k] <= qmul(om_in[NX2[k]], c[NX1[k]]);
        palc_u[k] <= qmul(al_in[NX1[k]], c[NX2[k]]);
        palc_n[k] <= qmul(al_in[NX2[k]], c[NX1[k]]);
        for (int j = 0; j < 3; j++) begin
          piw[k][j] <= qmul(im[k][j], om_in[j]);
          pia[k][j] <= qmul(im[k][j], al_in[j]);
        end
      end
    end
  end

  // Stage 2: cross and matrix sums; c x (a - g) products
  s32_t  a_2 [3], g_2 [3], om_2 [3], oc_2 [3], iw_2 [3];
  sum_t  fc_2 [3], ia_2 [3];
  prod_t pcd_u [3], pcd_n [3];

  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int k = 0; k < 3; k++) begin
        a_2[k]   <= a_1[k];
        g_2[k]   <= g_1[k];
        om_2[k]  <= om_1[k];
        oc_2[k]  <= sat32(sum_t'(pomc_u[k]) - sum_t'(pomc_n[k]));
        iw_2[k]  <= sat32(sum_t'(piw[k][0]) + sum_t'(piw[k][1]) + sum_t'(piw[k][2]));
        fc_2[k]  <= sum_t'(palc_u[k]) - sum_t'(palc_n[k]);
        ia_2[k]  <= sum_t'(pia[k][0]) + sum_t'(pia[k][1]) + sum_t'(pia[k][2]);
        pcd_u[k] <= qmul(c[NX1[k]], d_1[NX2[k]]);
        pcd_n[k] <= qmul(c[NX2[k]], d_1[NX1[k]]);
      end
    end
  end

  // Stage 3: omega x (omega x c) and omega x (I omega) products
  s32_t  a_3 [3], g_3 [3], cd_3 [3];
  sum_t  fc_3 [3], ia_3 [3];
  prod_t pot_u [3], pot_n [3], pow_u [3], pow_n [3];

  always_ff @(posedge clk) begin
    if (load[2]) begin
      for (int k = 0; k < 3; k++) begin
        a_3[k]   <= a_2[k];
        g_3[k]   <= g_2[k];
        fc_3[k]  <= fc_2[k];
        ia_3[k]  <= ia_2[k];
        cd_3[k]  <= sat32(sum_t'(pcd_u[k]) - sum_t'(pcd_n[k]));
        pot_u[k] <= qmul(om_2[NX1[k]], oc_2[NX2[k]]);
        pot_n[k] <= qmul(om_2[NX2[k]], oc_2[NX1[k]]);
        pow_u[k] <= qmul(om_2[NX1[k]], iw_2[NX2[k]]);
        pow_n[k] <= qmul(om_2[NX2[k]], iw_2[NX1[k]]);
      end
    end
  end

  // Stage 4: force sum before mass, torque partial, m * (c x (a - g))
  s32_t  fs_4 [3];
  sum_t  tp_4 [3];
  prod_t pmc_4 [3];

  always_ff @(posedge clk) begin
    if (load[3]) begin
      for (int k = 0; k < 3; k++) begin
        fs_4[k]  <= sat32(sum_t'(a_3[k]) + fc_3[k] + sum_t'(pot_u[k]) - sum_t'(pot_n[k])
                          - sum_t'(g_3[k]));
        tp_4[k]  <= ia_3[k] + sum_t'(pow_u[k]) - sum_t'(pow_n[k]);
        pmc_4[k] <= qmul(m, cd_3[k]);
      end
    end
  end

  // Stage 5: mass times force sum, final torque
  prod_t pms_5 [3];
  s32_t  tq_5 [3];

  always_ff @(posedge clk) begin
    if (load[4]) begin
      for (int k = 0; k < 3; k++) begin
        pms_5[k] <= qmul(m, fs_4[k]);
        tq_5[k]  <= sat32(tp_4[k] + sum_t'(pmc_4[k]));
      end
    end
  end

  // Stage 6: output word register
  always_ff @(posedge clk) begin
    if (load[5]) begin
      result.force_x  <= sat32(sum_t'(pms_5[0]));
      result.force_y  <= sat32(sum_t'(pms_5[1]));
      result.force_z  <= sat32(sum_t'(pms_5[2]));
      result.torque_x <= tq_5[0];
      result.torque_y <= tq_5[1];
      result.torque_z <= tq_5[2];
    end
  end

endmodule

@@ hw/rtl/rigid_body_wrench_model.sv @@
// Rigid body wrench predictor: force and torque of a held object from one IMU word.
// Pipeline: six register stages; a word moves through them in order and result_valid rises
// when it reaches the last stage, though a stall at the output can hold it back on the way.
// Throughput: one word per cycle; while the output stalls, a word still enters
// whenever some stage ahead of it is empty.
// Reset (rst, synchronous): pipeline empties and all configuration registers clear to 0.
// Depends on rbw_pkg, rbw_cfg, rbw_ctl, rbw_dpath.
module rigid_body_wrench_model (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  rbw_pkg::in_word_t              item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output rbw_pkg::out_word_t             result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);
  import rbw_pkg::*;

  cfg_t            cfg;
  logic [NSTG-1:0] load;
  logic [NSTG-1:0] stage_v;

  rbw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbw_ctl u_ctl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .load         (load),
    .stage_v      (stage_v)
  );

  rbw_dpath u_dpath (
    .clk    (clk),
    .cfg    (cfg),
    .load   (load),
    .item   (item),
    .result (result)
  );

  // A full, stalled pipeline must refuse new words
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&stage_v) && !result_ready) |-> !item_ready)
    else $error("input accepted into full stalled pipeline");

  // An empty first stage always takes a word
  a_empty_take: assert property (@(posedge clk) disable iff (rst)
    !stage_v[0] |-> item_ready)
    else $error("first stage empty but input not ready");

  // Reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (stage_v == '0))
    else $error("pipeline not empty after reset");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rigid_body_wrench_model: random and corner IMU words are
// checked against a fixed-point Newton-Euler predictor held inside the bench.
// Depends on rbw_pkg and the RTL under hw/rtl.
module tb_top;
  import rbw_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int MAX_REPORTS     = 50;
  localparam int Q16_MAX         = 2147483647;
  localparam int Q16_MIN         = -2147483647 - 1;

  // Index past the last register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int {SET_NOMINAL, SET_TYPICAL, SET_WIDE, SET_MAX, SET_MIN} setting_kind_e;
  typedef longint vec3_t [3];

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 item_valid = 1'b0;
  logic                 item_ready;
  in_word_t             item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  out_word_t            result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  // Bench copy of the configuration registers
  logic [30:0] mass_q = '0;
  s32_t        com_q [3] = '{default: '0};
  logic [63:0] inertia_q [3] = '{default: '0};

  out_word_t expected_wrench [$];
  string     wrench_fields [6] = '{"force_x", "force_y", "force_z",
                                   "torque_x", "torque_y", "torque_z"};

  int mismatch_count  = 0;
  int words_in        = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int settings_loaded = 0;

  bit sender_gaps  = 1'b0;
  bit sink_stalls  = 1'b0;
  int hold_off_len = 0;

  rigid_body_wrench_model dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Exact product, then floor shift back to Q16.16
  function automatic longint q_mul(longint x, longint y);
    longint p;
    p = x * y;
    return p >>> Q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > longint'(Q16_MAX)) return longint'(Q16_MAX);
    if (v < longint'(Q16_MIN)) return longint'(Q16_MIN);
    return v;
  endfunction

  function automatic vec3_t clamp3(vec3_t v);
    vec3_t r;
    for (int k = 0; k < 3; k++) r[k] = clamp32(v[k]);
    return r;
  endfunction

  function automatic vec3_t cross3(vec3_t u, vec3_t v);
    vec3_t r;
    r[0] = q_mul(u[1], v[2]) - q_mul(u[2], v[1]);
    r[1] = q_mul(u[2], v[0]) - q_mul(u[0], v[2]);
    r[2] = q_mul(u[0], v[1]) - q_mul(u[1], v[0]);
    return r;
  endfunction

  function automatic out_word_t predict_wrench(in_word_t w);
    vec3_t     lin, ang_a, ang_v, grav, com;
    vec3_t     alpha_c, omega_c, omega_omega_c, inr_alpha, inr_omega, gyro, a_minus_g, c_x_ag;
    longint    inr [3][3];
    longint    m;
    longint    res [6];
    out_word_t r;
    lin   = '{longint'(w.lin_acc_x), longint'(w.lin_acc_y), longint'(w.lin_acc_z)};
    ang_a = '{longint'(w.ang_acc_x), longint'(w.ang_acc_y), longint'(w.ang_acc_z)};
    ang_v = '{longint'(w.ang_vel_x), longint'(w.ang_vel_y), longint'(w.ang_vel_z)};
    grav  = '{longint'(w.grav_x), longint'(w.grav_y), longint'(w.grav_z)};
    com   = '{longint'(com_q[0]), longint'(com_q[1]), longint'(com_q[2])};
    m     = longint'(mass_q);

    // symmetric inertia, upper half of each register first
    inr[0][0] = longint'($signed(inertia_q[0][63:32]));
    inr[0][1] = longint'($signed(inertia_q[0][31:0]));
    inr[0][2] = longint'($signed(inertia_q[1][63:32]));
    inr[1][1] = longint'($signed(inertia_q[1][31:0]));
    inr[1][2] = longint'($signed(inertia_q[2][63:32]));
    inr[2][2] = longint'($signed(inertia_q[2][31:0]));
    inr[1][0] = inr[0][1];
    inr[2][0] = inr[0][2];
    inr[2][1] = inr[1][2];

    // force: m * (a + alpha x c + omega x (omega x c) - g)
    alpha_c       = cross3(ang_a, com);
    omega_c       = clamp3(cross3(ang_v, com));
    omega_omega_c = cross3(ang_v, omega_c);
    for (int k = 0; k < 3; k++)
      res[k] = clamp32(q_mul(m, clamp32(lin[k] + alpha_c[k] + omega_omega_c[k] - grav[k])));

    // torque: I*alpha + omega x (I*omega) + m * (c x (a - g))
    for (int k = 0; k < 3; k++) begin
      inr_alpha[k] = 0;
      inr_omega[k] = 0;
      for (int j = 0; j < 3; j++) begin
        inr_alpha[k] += q_mul(inr[k][j], ang_a[j]);
        inr_omega[k] += q_mul(inr[k][j], ang_v[j]);
      end
      a_minus_g[k] = clamp32(lin[k] - grav[k]);
    end
    gyro   = cross3(ang_v, clamp3(inr_omega));
    c_x_ag = clamp3(cross3(com, a_minus_g));
    for (int k = 0; k < 3; k++)
      res[3 + k] = clamp32(inr_alpha[k] + gyro[k] + q_mul(m, c_x_ag[k]));

    for (int k = 0; k < 6; k++) r[191 - 32*k -: 32] = res[k][31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: mirror register writes, capture accepted words, check results in order
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin : scoreboard
    out_word_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASS:    mass_q = cfg_data[30:0];
          REG_COM_X:   com_q[0] = cfg_data[31:0];
          REG_COM_Y:   com_q[1] = cfg_data[31:0];
          REG_COM_Z:   com_q[2] = cfg_data[31:0];
          REG_IXX_IXY: inertia_q[0] = cfg_data;
          REG_IXZ_IYY: inertia_q[1] = cfg_data;
          REG_IYZ_IZZ: inertia_q[2] = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        expected_wrench.push_back(predict_wrench(item));
        words_in++;
      end
      if (result_valid && result_ready) begin
        results_checked++;
        if (expected_wrench.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing expected", result));
        end else begin
          want = expected_wrench.pop_front();
          for (int k = 0; k < 6; k++)
            if (result[191 - 32*k -: 32] !== want[191 - 32*k -: 32])
              report_mismatch($sformatf("result %0d %s: got %h expected %h", results_checked,
                              wrench_fields[k], result[191 - 32*k -: 32],
                              want[191 - 32*k -: 32]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        result_ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        result_ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // No handshake of any kind for too long means the block is hung
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_wrench.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Signed value with magnitude below 2^bits
  function automatic s32_t small_q16(int bits);
    s32_t v;
    v = s32_t'($urandom_range(0, (1 << bits) - 1));
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Mostly physical magnitudes, some full-range noise and exact corners
  function automatic s32_t random_q16();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 4))
        0: return s32_t'(Q16_MAX);
        1: return s32_t'(Q16_MIN);
        2: return '0;
        3: return 32'sh0001_0000;
        default: return -32'sh0001_0000;
      endcase
    end
    if (pick < 30) return s32_t'($urandom());
    return small_q16($urandom_range(4, 22));
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    for (int k = 0; k < 12; k++) w[383 - 32*k -: 32] = random_q16();
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  // Stop sending, let every result drain, then allow the pipeline to settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_wrench.size() != 0);
    repeat (NSTG + 4) @(posedge clk);
  endtask

  // Write every register and the unmapped index (with junk in the unused upper bits) while idle
  task automatic load_setting(input setting_kind_e kind);
    logic [31:0] mass_v;
    s32_t        com_v [3];
    s32_t        inr_v [6];
    wait_idle();
    case (kind)
      SET_NOMINAL: begin
        mass_v = 32'h0002_0000;
        com_v  = '{32'sh0000_8000, -32'sh0000_4000, 32'sh0000_2000};
        inr_v  = '{32'sh0001_0000, 32'sh0000_199a, -32'sh0000_3333,
                   32'sh0002_0000, 32'sh0000_0ccd, 32'sh0003_0000};
      end
      SET_TYPICAL: begin
        mass_v     = $urandom_range(0, 1 << 22);
        mass_v[31] = 1'($urandom_range(0, 1));
        foreach (com_v[k]) com_v[k] = small_q16(17);
        foreach (inr_v[k]) inr_v[k] = small_q16(18);
      end
      SET_WIDE: begin
        mass_v = $urandom();
        foreach (com_v[k]) com_v[k] = $urandom();
        foreach (inr_v[k]) inr_v[k] = $urandom();
      end
      SET_MAX: begin
        mass_v = '1;
        com_v  = '{default: s32_t'(Q16_MAX)};
        inr_v  = '{default: s32_t'(Q16_MAX)};
      end
      default: begin
        mass_v = 32'h8000_0000;
        com_v  = '{default: s32_t'(Q16_MIN)};
        inr_v  = '{default: s32_t'(Q16_MIN)};
      end
    endcase
    write_reg(REG_MASS, {$urandom(), mass_v});
    write_reg(REG_COM_X, {$urandom(), com_v[0]});
    write_reg(REG_COM_Y, {$urandom(), com_v[1]});
    write_reg(REG_COM_Z, {$urandom(), com_v[2]});
    write_reg(REG_IXX_IXY, {inr_v[0], inr_v[1]});
    write_reg(REG_IXZ_IYY, {inr_v[2], inr_v[3]});
    write_reg(REG_IYZ_IZZ, {inr_v[4], inr_v[5]});
    write_reg(REG_UNMAPPED, {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // All-max, all-min and alternating words
  task automatic send_corners();
    send_word({12{s32_t'(Q16_MAX)}});
    send_word({12{s32_t'(Q16_MIN)}});
    send_word({6{s32_t'(Q16_MAX), s32_t'(Q16_MIN)}});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers clear on reset, so everything predicts zero
  task automatic test_reset_defaults();
    send_word({12{s32_t'(Q16_MAX)}});
    send_word(random_word());
  endtask

  task automatic test_nominal_corners();
    in_word_t w;
    load_setting(SET_NOMINAL);
    send_word('0);
    // gravity only, about -9.81 in z
    w = '0;
    w.grav_z = -32'sd642908;
    send_word(w);
    w = '0;
    w.lin_acc_x = 32'sh0001_0000;
    w.ang_vel_z = 32'sh0001_0000;
    w.ang_acc_y = -32'sh0000_8000;
    send_word(w);
    // one LSB negative everywhere: products must floor, not truncate toward zero
    send_word({12{-32'sd1}});
    send_corners();
    // a - g overflows 32 bits and must clamp before the c x (a - g) product
    w = '0;
    w.lin_acc_x = s32_t'(Q16_MAX);
    w.grav_x    = s32_t'(Q16_MIN);
    w.lin_acc_y = s32_t'(Q16_MIN);
    w.grav_y    = s32_t'(Q16_MAX);
    send_word(w);
    // large spin drives I*omega into saturation
    w = '0;
    w.ang_vel_x = s32_t'(Q16_MAX);
    w.ang_vel_y = s32_t'(Q16_MAX);
    w.ang_vel_z = s32_t'(Q16_MIN);
    send_word(w);
  endtask

  task automatic test_extreme_settings();
    load_setting(SET_MAX);
    send_corners();
    load_setting(SET_MIN);
    send_corners();
  endtask

  // Bits above the mass and com_x register widths and the unmapped index must be ignored
  task automatic test_register_masking();
    wait_idle();
    write_reg(REG_MASS, 64'hffff_ffff_8000_0000);
    write_reg(REG_COM_X, 64'h1234_5678_0001_0000);
    write_reg(REG_UNMAPPED, '1);
    cfg_valid <= 1'b0;
    send_word({12{32'sh0003_0000}});
    send_word(random_word());
    wait_idle();
    write_reg(REG_MASS, 64'hdead_beef_0001_8000);
    cfg_valid <= 1'b0;
    send_word(random_word());
    send_word({12{-32'sh0002_0000}});
  endtask

  task automatic test_random_settings();
    setting_kind_e plan [6] = '{SET_TYPICAL, SET_WIDE, SET_MAX, SET_TYPICAL,
                                SET_MIN, SET_TYPICAL};
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    foreach (plan[p]) begin
      load_setting(plan[p]);
      repeat (80) send_word(random_word());
    end
  endtask

  // Output held off while words keep coming: pipeline fills and input stalls
  task automatic test_output_hold_off();
    load_setting(SET_TYPICAL);
    sender_gaps  = 1'b0;
    sink_stalls  = 1'b0;
    hold_off_len = HOLD_OFF_CYCLES;
    repeat (40) send_word(random_word());
  endtask

  // Back-to-back words with no idling on either side
  task automatic test_full_rate();
    load_setting(SET_TYPICAL);
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (110) send_word(random_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_nominal_corners();
    test_extreme_settings();
    test_register_masking();
    test_random_settings();
    test_output_hold_off();
    test_full_rate();
    wait_idle();
    if (expected_wrench.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_wrench.size()));
    $display("covered %0d input words and %0d checked results over %0d settings (%0d writes)",
             words_in, results_checked, settings_loaded, reg_writes);
    $display("incl. reset defaults, saturation corners, register masking, %0d-cycle hold-off",
             HOLD_OFF_CYCLES);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ rigid_body_wrench_model.f @@
hw/rtl/rbw_pkg.sv
hw/rtl/rbw_cfg.sv
hw/rtl/rbw_ctl.sv
hw/rtl/rbw_dpath.sv
hw/rtl/rigid_body_wrench_model.sv
dv/tb_top.sv
